// ----- src/rdeq_pkg.sv -----
package rdeq_pkg;

  localparam int unsigned MAX_DEPTH = 16;

  // Pointer, count and capacity widths. The capacity can reach the smallest power
  // of two at or above MAX_DEPTH, so it is given one more bit than the count.
  localparam int unsigned PtrW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CapW = CntW + 1;

  localparam int unsigned IdW  = 16;
  localparam int unsigned OutW = 5;

  localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [1:0] KIND_POP_BACK   = 2'd3;

  localparam logic [CapW-1:0] CAP_RESET = CapW'(4);
  localparam logic [CapW-1:0] CAP_MIN   = CapW'(2);

  typedef struct packed {
    logic load;
    logic capture;
  } rdeq_cmd_t;

endpackage

// ----- src/resizable_double_ended_queue_top.sv -----
// Flow: a result word passes through the registered slot read and then the output
// register, and waits while the output register still holds a word that the
// receiver stalls. The input stalls until the result is loaded into the output
// register, so no new word is taken before the last one is through.
// Reset: asynchronous, active low; the deque is empty, the head is zero and the
// capacity is four. Slot contents are undefined until written; no clearing pass.
module resizable_double_ended_queue_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                kind_i,
  input  logic [rdeq_pkg::IdW-1:0]  task_id_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [rdeq_pkg::IdW-1:0]  popped_id_o,
  output logic                      pop_valid_o,
  output logic                      was_empty_o,
  output logic                      push_refused_o,
  output logic [rdeq_pkg::OutW-1:0] element_count_o,
  output logic [rdeq_pkg::OutW-1:0] logical_capacity_o
);

  rdeq_pkg::rdeq_cmd_t cmd;

  rdeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  rdeq_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .kind_i             (kind_i),
    .task_id_i          (task_id_i),
    .popped_id_o        (popped_id_o),
    .pop_valid_o        (pop_valid_o),
    .was_empty_o        (was_empty_o),
    .push_refused_o     (push_refused_o),
    .element_count_o    (element_count_o),
    .logical_capacity_o (logical_capacity_o)
  );

endmodule

// ----- src/rdeq_ctrl.sv -----
module rdeq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rdeq_pkg::rdeq_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CAPT = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.capture = (state_q == ST_CAPT) && out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd_o.load) state_d = ST_CAPT;
      ST_CAPT: if (cmd_o.capture) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // The output register holds a word until the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- src/rdeq_datapath.sv -----
module rdeq_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rdeq_pkg::rdeq_cmd_t         cmd_i,
  input  logic [1:0]                  kind_i,
  input  logic [rdeq_pkg::IdW-1:0]    task_id_i,
  output logic [rdeq_pkg::IdW-1:0]    popped_id_o,
  output logic                        pop_valid_o,
  output logic                        was_empty_o,
  output logic                        push_refused_o,
  output logic [rdeq_pkg::OutW-1:0]   element_count_o,
  output logic [rdeq_pkg::OutW-1:0]   logical_capacity_o
);

  localparam int unsigned PtrW = rdeq_pkg::PtrW;
  localparam int unsigned CntW = rdeq_pkg::CntW;
  localparam int unsigned CapW = rdeq_pkg::CapW;
  localparam int unsigned IdW  = rdeq_pkg::IdW;
  localparam int unsigned OutW = rdeq_pkg::OutW;
  localparam logic [PtrW:0] Depth = (PtrW+1)'(rdeq_pkg::MAX_DEPTH);

  logic [IdW-1:0] slots_q [rdeq_pkg::MAX_DEPTH];

  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CapW-1:0] cap_q, cap_d;
  logic            valid_q, valid_d, empty_q, empty_d, refused_q, refused_d;
  logic [IdW-1:0]  rd_q;

  logic            is_push, is_front, full, none;
  logic [PtrW:0]   back_sum, last_sum;
  logic [PtrW-1:0] back_ptr, last_ptr, front_ptr, addr;
  logic            wr_en, rd_en;
  logic [CntW-1:0] count_dec;
  logic [CapW-1:0] cap_half;

  always_comb begin
    is_push  = (kind_i == rdeq_pkg::KIND_PUSH_FRONT) || (kind_i == rdeq_pkg::KIND_PUSH_BACK);
    is_front = (kind_i == rdeq_pkg::KIND_PUSH_FRONT) || (kind_i == rdeq_pkg::KIND_POP_FRONT);
    full     = (count_q >= CntW'(rdeq_pkg::MAX_DEPTH));
    none     = (count_q == '0);

    // Circular positions: one past the back, the back itself, one before the front.
    back_sum = {1'b0, head_q} + (PtrW+1)'(count_q);
    back_ptr = (back_sum >= Depth) ? PtrW'(back_sum - Depth) : back_sum[PtrW-1:0];
    last_sum = {1'b0, head_q} + (PtrW+1)'(count_q) - (PtrW+1)'(1);
    last_ptr = (last_sum >= Depth) ? PtrW'(last_sum - Depth) : last_sum[PtrW-1:0];
    front_ptr = (head_q == '0) ? PtrW'(rdeq_pkg::MAX_DEPTH - 1) : head_q - PtrW'(1);

    unique case (kind_i)
      rdeq_pkg::KIND_PUSH_FRONT: addr = front_ptr;
      rdeq_pkg::KIND_PUSH_BACK:  addr = back_ptr;
      rdeq_pkg::KIND_POP_FRONT:  addr = head_q;
      default:                   addr = last_ptr;
    endcase

    wr_en     = cmd_i.load && is_push && !full;
    rd_en     = cmd_i.load && !is_push && !none;
    count_dec = count_q - CntW'(1);
    cap_half  = cap_q >> 1;
  end

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    cap_d     = cap_q;
    valid_d   = 1'b0;
    empty_d   = 1'b0;
    refused_d = 1'b0;
    if (is_push) begin
      if (full) begin
        refused_d = 1'b1;
      end else begin
        if (CapW'(count_q) == cap_q) cap_d = cap_q << 1;
        if (is_front) head_d = front_ptr;
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (none) begin
        empty_d = 1'b1;
      end else begin
        valid_d = 1'b1;
        count_d = count_dec;
        if (is_front) begin
          head_d = (head_q == PtrW'(rdeq_pkg::MAX_DEPTH - 1)) ? '0 : head_q + PtrW'(1);
        end
        if (CapW'(count_dec) <= (cap_q >> 2)) begin
          cap_d = (cap_half > rdeq_pkg::CAP_MIN) ? cap_half : rdeq_pkg::CAP_MIN;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) slots_q[addr] <= task_id_i;
    if (rd_en) rd_q <= slots_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      cap_q   <= rdeq_pkg::CAP_RESET;
    end else if (cmd_i.load) begin
      head_q  <= head_d;
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      valid_q   <= valid_d;
      empty_q   <= empty_d;
      refused_q <= refused_d;
    end
  end

  // Output word register, loaded once the slot read has settled.
  logic [CntW+OutW-1:0] count_ext;
  logic [CapW+OutW-1:0] cap_ext;
  assign count_ext = {{OutW{1'b0}}, count_q};
  assign cap_ext   = {{OutW{1'b0}}, cap_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      popped_id_o        <= valid_q ? rd_q : '0;
      pop_valid_o        <= valid_q;
      was_empty_o        <= empty_q;
      push_refused_o     <= refused_q;
      element_count_o    <= count_ext[OutW-1:0];
      logical_capacity_o <= cap_ext[OutW-1:0];
    end
  end

endmodule
